// ===== rtl/edge_timed_serial_event_decoder_assert.svh =====
// Assertion helpers used by the checker file.
`ifndef EDGE_TIMED_SERIAL_EVENT_DECODER_ASSERT_SVH
`define EDGE_TIMED_SERIAL_EVENT_DECODER_ASSERT_SVH

// Same-cycle implication.
`define ETSED_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("etsed assertion failed");

// Next-cycle implication.
`define ETSED_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("etsed assertion failed");

`endif

// ===== rtl/etsed_pkg.sv =====
// ----------------------------------------------------------------------------
// etsed_pkg
// Types, widths and decode constants of the edge-timed serial event decoder.
// ----------------------------------------------------------------------------
package etsed_pkg;

  localparam int PERIOD_W   = 24;
  localparam int SCALE_W    = 10;
  localparam int INTERVAL_W = 31;
  localparam int SUM_W      = 32;
  localparam int KIND_W     = 3;
  localparam int KEY_W      = 7;
  localparam int AMOUNT_W   = 9;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int COUNT_W    = 4;
  localparam int BITS_W     = 4;
  localparam int POS_W      = 5;
  localparam int BYTE_W     = 8;
  localparam int DIFF_W     = 6;
  localparam int PROD_W     = 16;
  localparam int MAG_W      = 15;
  localparam int RECIP_W    = 13;
  localparam int SCALED_W   = 28;
  localparam int QUOT_W     = 8;
  localparam int RECIP_SHIFT = 19;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [PERIOD_W-1:0] RESET_BIT_PERIOD = 24'd504000;
  localparam logic [SCALE_W-1:0]  RESET_SCALE      = 10'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SCALE = 1'b1;

  localparam logic [COUNT_W-1:0] MAX_COUNT  = 4'd15;
  localparam logic [POS_W-1:0]   FULL_BYTE  = 5'd8;

  localparam logic [BYTE_W-1:0] LAST_KEY_DOWN    = 8'd77;
  localparam logic [BYTE_W-1:0] FIRST_KEY_UP     = 8'd78;
  localparam logic [BYTE_W-1:0] LAST_KEY_UP      = 8'd155;
  localparam logic [BYTE_W-1:0] BUTTON_DOWN_CODE = 8'd156;
  localparam logic [BYTE_W-1:0] BUTTON_UP_CODE   = 8'd157;
  localparam logic [BYTE_W-1:0] LAST_MOVE_X      = 8'd206;
  localparam logic [BYTE_W-1:0] CENTER_X         = 8'd182;
  localparam logic [BYTE_W-1:0] CENTER_Y         = 8'd231;

  // floor(m / 100) == (m * 5243) >> 19 for every m below 43699
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

  typedef enum logic [KIND_W-1:0] {
    KIND_KEY_DOWN,
    KIND_KEY_UP,
    KIND_BUTTON_DOWN,
    KIND_BUTTON_UP,
    KIND_MOVE_X,
    KIND_MOVE_Y
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAT,
    ST_DIV,
    ST_APPLY,
    ST_MUL,
    ST_RECIP,
    ST_EMIT
  } back_state_t;

  // Classified edge: interval already biased by half a bit period.
  typedef struct packed {
    logic             rising;
    logic             overflow;
    logic [SUM_W-1:0] rounded;
  } edge_item_t;

endpackage

// ===== rtl/etsed_if.sv =====
// ----------------------------------------------------------------------------
// etsed_if
// Valid/ready channels: line edges in, decoded events out.
// ----------------------------------------------------------------------------
interface etsed_edge_if;
  logic                                valid;
  logic                                ready;
  logic                                edge_rising;
  logic [etsed_pkg::INTERVAL_W-1:0]    interval_ns;
  logic                                interval_overflow;

  modport source (output valid, edge_rising, interval_ns, interval_overflow, input ready);
  modport sink   (input valid, edge_rising, interval_ns, interval_overflow, output ready);
endinterface

interface etsed_event_if;
  logic                                valid;
  logic                                ready;
  logic [etsed_pkg::KIND_W-1:0]        event_kind;
  logic [etsed_pkg::KEY_W-1:0]         key_index;
  logic signed [etsed_pkg::AMOUNT_W-1:0] move_amount;

  modport source (output valid, event_kind, key_index, move_amount, input ready);
  modport sink   (input valid, event_kind, key_index, move_amount, output ready);
endinterface

// ===== rtl/edge_timed_serial_event_decoder.sv =====
// ----------------------------------------------------------------------------
// edge_timed_serial_event_decoder
// Serial byte receiver driven by timed line edges; each byte becomes one event.
// ----------------------------------------------------------------------------
//   channel   dir  payload
//   edges     in   edge_rising, interval_ns[30:0], interval_overflow
//   events    out  event_kind[2:0], key_index[6:0], move_amount[8:0] signed
//   cfg_*     in   cfg_we, cfg_index, cfg_data[23:0] (write only)
//
// Idle and overflowed edges retire in the idle state; a counted edge goes
// through the saturation check, the 4-step restoring divider and apply (a
// saturated count skips the divider). A completed byte adds multiply,
// reciprocal scale and output load. rst is synchronous; the edge queue
// absorbs input while the back end or a stalled output register holds.
// ----------------------------------------------------------------------------
module edge_timed_serial_event_decoder #(
  parameter int QUEUE_DEPTH = etsed_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  etsed_edge_if.sink                         edges,
  etsed_event_if.source                      events,
  input  logic                               cfg_we,
  input  logic [etsed_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [etsed_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [etsed_pkg::PERIOD_W-1:0] bit_period;
  logic [etsed_pkg::SCALE_W-1:0]  move_scale;
  etsed_pkg::edge_item_t          item;
  logic                           item_valid;
  logic                           item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= etsed_pkg::RESET_BIT_PERIOD;
      move_scale <= etsed_pkg::RESET_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        etsed_pkg::CFG_BIT_PERIOD: bit_period <= cfg_data[etsed_pkg::PERIOD_W-1:0];
        etsed_pkg::CFG_MOVE_SCALE: move_scale <= cfg_data[etsed_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  etsed_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .edges      (edges),
    .bit_period (bit_period),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  etsed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .bit_period (bit_period),
    .move_scale (move_scale),
    .events     (events)
  );

endmodule

// ===== rtl/etsed_front.sv =====
// ----------------------------------------------------------------------------
// etsed_front
// Takes line edges, biases the interval by half a bit period and queues them.
// ----------------------------------------------------------------------------
module etsed_front #(
  parameter int DEPTH = etsed_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  etsed_edge_if.sink                        edges,
  input  logic [etsed_pkg::PERIOD_W-1:0]    bit_period,
  output etsed_pkg::edge_item_t             item,
  output logic                              item_valid,
  input  logic                              item_take
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  etsed_pkg::edge_item_t queue [DEPTH];
  etsed_pkg::edge_item_t incoming;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic push;
  logic pop;

  assign edges.ready = (fill != CNT_W'(DEPTH));
  assign item_valid  = (fill != '0);
  assign item        = queue[rd_ptr];
  assign push        = edges.valid && edges.ready;
  assign pop         = item_valid && item_take;

  always_comb begin
    incoming.rising   = edges.edge_rising;
    incoming.overflow = edges.interval_overflow;
    incoming.rounded  = etsed_pkg::SUM_W'(edges.interval_ns)
                      + etsed_pkg::SUM_W'(bit_period >> 1);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/etsed_back.sv =====
// ----------------------------------------------------------------------------
// etsed_back
// Frame sequencer: rounds the interval to bit periods with a 4-step restoring
// divider, shifts bits into the byte and decodes a full byte into an event.
// ----------------------------------------------------------------------------
module etsed_back (
  input  logic                              clk,
  input  logic                              rst,
  input  etsed_pkg::edge_item_t             item,
  input  logic                              item_valid,
  output logic                              item_take,
  input  logic [etsed_pkg::PERIOD_W-1:0]    bit_period,
  input  logic [etsed_pkg::SCALE_W-1:0]     move_scale,
  etsed_event_if.source                     events
);

  etsed_pkg::back_state_t state, state_next;

  logic                               frame_active, frame_active_next;
  logic                               start_done, start_done_next;
  logic [etsed_pkg::BITS_W-1:0]       bits_rcvd, bits_rcvd_next;
  logic [etsed_pkg::BYTE_W-1:0]       byte_bits, byte_bits_next;
  logic                               rising, rising_next;
  logic [etsed_pkg::SUM_W-1:0]        rem, rem_next;
  logic [etsed_pkg::COUNT_W-1:0]      count, count_next;
  logic [1:0]                         step, step_next;
  logic signed [etsed_pkg::PROD_W-1:0] prod, prod_next;
  logic                               neg, neg_next;
  logic [etsed_pkg::QUOT_W-1:0]       quot, quot_next;

  logic                               out_valid, out_valid_next;
  logic [etsed_pkg::KIND_W-1:0]       out_kind, out_kind_next;
  logic [etsed_pkg::KEY_W-1:0]        out_key, out_key_next;
  logic signed [etsed_pkg::AMOUNT_W-1:0] out_amount, out_amount_next;

  logic [etsed_pkg::SUM_W-1:0]        shifted;
  logic [etsed_pkg::COUNT_W-1:0]      n_bits;
  logic [etsed_pkg::POS_W-1:0]        end_pos;
  logic signed [etsed_pkg::DIFF_W-1:0] diff;
  logic [etsed_pkg::MAG_W-1:0]        mag;
  logic [etsed_pkg::SCALED_W-1:0]     scaled;
  etsed_pkg::event_kind_t             kind;
  logic [etsed_pkg::KEY_W-1:0]        key;
  logic signed [etsed_pkg::AMOUNT_W-1:0] amount;

  assign events.valid       = out_valid;
  assign events.event_kind  = out_kind;
  assign events.key_index   = out_key;
  assign events.move_amount = out_amount;

  // Byte classification
  always_comb begin
    kind = etsed_pkg::KIND_MOVE_Y;
    key  = '0;
    if (byte_bits <= etsed_pkg::LAST_KEY_DOWN) begin
      kind = etsed_pkg::KIND_KEY_DOWN;
      key  = byte_bits[etsed_pkg::KEY_W-1:0];
    end else if (byte_bits <= etsed_pkg::LAST_KEY_UP) begin
      kind = etsed_pkg::KIND_KEY_UP;
      key  = etsed_pkg::KEY_W'(byte_bits - etsed_pkg::FIRST_KEY_UP);
    end else if (byte_bits == etsed_pkg::BUTTON_DOWN_CODE) begin
      kind = etsed_pkg::KIND_BUTTON_DOWN;
    end else if (byte_bits == etsed_pkg::BUTTON_UP_CODE) begin
      kind = etsed_pkg::KIND_BUTTON_UP;
    end else if (byte_bits <= etsed_pkg::LAST_MOVE_X) begin
      kind = etsed_pkg::KIND_MOVE_X;
    end
    // both move ranges stay within -24..24 around their center
    diff = (kind == etsed_pkg::KIND_MOVE_X) ?
           etsed_pkg::DIFF_W'(byte_bits - etsed_pkg::CENTER_X) :
           etsed_pkg::DIFF_W'(byte_bits - etsed_pkg::CENTER_Y);
    amount = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  assign shifted = etsed_pkg::SUM_W'(bit_period) << step;
  assign mag     = prod[etsed_pkg::PROD_W-1] ? etsed_pkg::MAG_W'(-prod) : etsed_pkg::MAG_W'(prod);
  assign scaled  = etsed_pkg::SCALED_W'(mag) * etsed_pkg::SCALED_W'(etsed_pkg::RECIP_100);

  always_comb begin
    state_next        = state;
    frame_active_next = frame_active;
    start_done_next   = start_done;
    bits_rcvd_next    = bits_rcvd;
    byte_bits_next    = byte_bits;
    rising_next       = rising;
    rem_next          = rem;
    count_next        = count;
    step_next         = step;
    prod_next         = prod;
    neg_next          = neg;
    quot_next         = quot;
    out_valid_next    = out_valid && !events.ready;
    out_kind_next     = out_kind;
    out_key_next      = out_key;
    out_amount_next   = out_amount;
    item_take         = 1'b0;
    n_bits            = count;
    end_pos           = '0;

    unique case (state)
      etsed_pkg::ST_IDLE: begin
        if (item_valid) begin
          item_take = 1'b1;
          if (!frame_active) begin
            if (!item.rising) begin
              frame_active_next = 1'b1;
              bits_rcvd_next    = '0;
              start_done_next   = 1'b0;
            end
          end else if (!item.overflow) begin
            rem_next    = item.rounded;
            rising_next = item.rising;
            state_next  = etsed_pkg::ST_SAT;
          end
        end
      end

      etsed_pkg::ST_SAT: begin
        // zero period or quotient of 16 or more saturates
        if (bit_period == '0 || rem >= {4'b0, bit_period, 4'b0}) begin
          count_next = etsed_pkg::MAX_COUNT;
          state_next = etsed_pkg::ST_APPLY;
        end else begin
          count_next = '0;
          step_next  = 2'd3;
          state_next = etsed_pkg::ST_DIV;
        end
      end

      etsed_pkg::ST_DIV: begin
        if (rem >= shifted) begin
          rem_next          = rem - shifted;
          count_next[step]  = 1'b1;
        end
        if (step == 2'd0) begin
          state_next = etsed_pkg::ST_APPLY;
        end else begin
          step_next = step - 1'b1;
        end
      end

      etsed_pkg::ST_APPLY: begin
        // first low run also covers the start bit
        if (rising && !start_done && count != '0) begin
          n_bits          = count - 1'b1;
          start_done_next = 1'b1;
        end
        end_pos = etsed_pkg::POS_W'(bits_rcvd) + etsed_pkg::POS_W'(n_bits);
        for (int i = 0; i < etsed_pkg::BYTE_W; i++) begin
          if (etsed_pkg::POS_W'(i) >= etsed_pkg::POS_W'(bits_rcvd) &&
              etsed_pkg::POS_W'(i) < end_pos) begin
            byte_bits_next[i] = !rising;
          end
        end
        state_next = etsed_pkg::ST_IDLE;
        if (end_pos > etsed_pkg::FULL_BYTE) begin
          frame_active_next = 1'b0;
        end else begin
          bits_rcvd_next = end_pos[etsed_pkg::BITS_W-1:0];
          if (end_pos == etsed_pkg::FULL_BYTE) begin
            frame_active_next = 1'b0;
            state_next        = etsed_pkg::ST_MUL;
          end
        end
      end

      etsed_pkg::ST_MUL: begin
        prod_next  = etsed_pkg::PROD_W'(diff)
                   * etsed_pkg::PROD_W'($signed({1'b0, move_scale}));
        state_next = etsed_pkg::ST_RECIP;
      end

      etsed_pkg::ST_RECIP: begin
        neg_next   = prod[etsed_pkg::PROD_W-1];
        quot_next  = scaled[etsed_pkg::RECIP_SHIFT +: etsed_pkg::QUOT_W];
        state_next = etsed_pkg::ST_EMIT;
      end

      etsed_pkg::ST_EMIT: begin
        if (!out_valid || events.ready) begin
          out_valid_next = 1'b1;
          out_kind_next  = kind;
          out_key_next   = key;
          out_amount_next = (kind == etsed_pkg::KIND_MOVE_X || kind == etsed_pkg::KIND_MOVE_Y)
                          ? amount : '0;
          state_next     = etsed_pkg::ST_IDLE;
        end
      end

      default: state_next = etsed_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= etsed_pkg::ST_IDLE;
      frame_active <= 1'b0;
      start_done   <= 1'b0;
      bits_rcvd    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      frame_active <= frame_active_next;
      start_done   <= start_done_next;
      bits_rcvd    <= bits_rcvd_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    byte_bits  <= byte_bits_next;
    rising     <= rising_next;
    rem        <= rem_next;
    count      <= count_next;
    step       <= step_next;
    prod       <= prod_next;
    neg        <= neg_next;
    quot       <= quot_next;
    out_kind   <= out_kind_next;
    out_key    <= out_key_next;
    out_amount <= out_amount_next;
  end

endmodule

// ===== rtl/etsed_checker.sv =====
// ----------------------------------------------------------------------------
// etsed_checker
// Port-level checks on the event output of the decoder.
// ----------------------------------------------------------------------------
`include "edge_timed_serial_event_decoder_assert.svh"

module etsed_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 events_valid,
  input logic                                 events_ready,
  input logic [etsed_pkg::KIND_W-1:0]         event_kind,
  input logic [etsed_pkg::KEY_W-1:0]          key_index,
  input logic signed [etsed_pkg::AMOUNT_W-1:0] move_amount
);

  logic is_key;
  logic is_move;

  assign is_key  = (event_kind == etsed_pkg::KIND_KEY_DOWN) ||
                   (event_kind == etsed_pkg::KIND_KEY_UP);
  assign is_move = (event_kind == etsed_pkg::KIND_MOVE_X) ||
                   (event_kind == etsed_pkg::KIND_MOVE_Y);

  `ETSED_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !events_valid)
  `ETSED_ASSERT_NEXT(a_stall_hold, clk, rst, events_valid && !events_ready, events_valid && $stable(event_kind) && $stable(key_index) && $stable(move_amount))
  `ETSED_ASSERT_NOW(a_key_only_keys, clk, rst, events_valid && !is_key, key_index == '0)
  `ETSED_ASSERT_NOW(a_key_range, clk, rst, events_valid && is_key, key_index <= etsed_pkg::KEY_W'(etsed_pkg::LAST_KEY_DOWN))
  `ETSED_ASSERT_NOW(a_move_only_moves, clk, rst, events_valid && !is_move, move_amount == '0)

endmodule

bind edge_timed_serial_event_decoder etsed_checker u_etsed_checker (
  .clk          (clk),
  .rst          (rst),
  .events_valid (events.valid),
  .events_ready (events.ready),
  .event_kind   (events.event_kind),
  .key_index    (events.key_index),
  .move_amount  (events.move_amount)
);
